[design/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// nsr_pkg
// Types and constants shared by the Newton square-root controller, datapath
// and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 24;
    localparam int ITER_W     = 7;

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 7'd20;
    localparam logic [ITER_W-1:0] MAX_ITER_CAP   = 7'd64;
    localparam logic [ITER_W-1:0] MAX_ITER_MIN   = 7'd1;
    localparam logic [ROOT_W-1:0] ROOT_MAX       = {ROOT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_FINISH = 4'b1000
    } nsr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic step;
        logic publish;
    } nsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_zero;
        logic div_done;
        logic same;
        logic limit_hit;
        logic out_free;
    } nsr_status_t;

endpackage

`default_nettype wire

[design/nsr_div.sv]
// ----------------------------------------------------------------------------
// nsr_div
// Restoring unsigned divider, one quotient bit per cycle. The divisor is
// latched at start; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_div #(
    parameter int WIDTH = 48
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0]      quotient,
    output logic                  done
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   partial;
    logic [WIDTH:0]   diff;
    logic             ge;

    always_comb
    begin
        partial = {rem_reg, quo_reg[WIDTH-1]};
        diff    = partial - {1'b0, dvs_reg};
        ge      = (partial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Partial remainder stays below the divisor, so the low bits hold it.
            rem_next = ge ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

[design/nsr_datapath.sv]
// ----------------------------------------------------------------------------
// nsr_datapath
// Guess register, step counter, iteration limit register, shared divider and
// the output register of the Newton square root.
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_datapath
    import nsr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire nsr_cmd_t              cmd,
    output nsr_status_t                status,
    input  wire logic [RADICAND_W-1:0] radicand,
    input  wire logic                  cfg_wr_en,
    input  wire logic [ITER_W-1:0]     cfg_wr_data,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [ROOT_W-1:0]          root,
    output logic                       converged,
    output logic [ITER_W-1:0]          iterations_used
);

    localparam int GW = RADICAND_W + FRAC_BITS;

    logic [RADICAND_W-1:0] x_reg;
    logic [GW-1:0]         g_reg, g_next;
    logic [ITER_W-1:0]     steps_reg, steps_next;
    logic                  conv_reg, conv_next;
    logic [ITER_W-1:0]     max_iter_reg;

    logic                  out_valid_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic                  converged_reg;
    logic [ITER_W-1:0]     iter_out_reg;

    logic [GW-1:0]         dividend;
    logic [GW-1:0]         divisor;
    logic [GW-1:0]         quotient;
    logic                  div_done;
    logic [GW:0]           sum;
    logic [GW-1:0]         g_new;
    logic [GW-1:0]         g_init;
    logic [ITER_W-1:0]     limit;
    logic [ITER_W-1:0]     steps_inc;
    logic                  in_zero;
    logic [ROOT_W-1:0]     root_sat;

    assign dividend = {x_reg, {FRAC_BITS{1'b0}}};
    assign divisor  = (g_reg == '0) ? GW'(1) : g_reg;

    nsr_div #(
        .WIDTH (GW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        in_zero = (radicand == '0);
        sum     = {1'b0, g_reg} + {1'b0, quotient};
        g_new   = sum[GW:1];
        if (radicand[RADICAND_W-1:1] == '0) begin
            g_init = GW'(1);
        end else begin
            g_init = GW'(radicand[RADICAND_W-1:1]);
        end
        if (max_iter_reg < MAX_ITER_MIN) begin
            limit = MAX_ITER_MIN;
        end else if (max_iter_reg > MAX_ITER_CAP) begin
            limit = MAX_ITER_CAP;
        end else begin
            limit = max_iter_reg;
        end
        steps_inc = steps_reg + ITER_W'(1);
        root_sat  = (g_reg > GW'(ROOT_MAX)) ? ROOT_MAX : g_reg[ROOT_W-1:0];
    end

    always_comb
    begin
        status.in_zero   = in_zero;
        status.div_done  = div_done;
        status.same      = (g_new == g_reg);
        status.limit_hit = (steps_inc >= limit);
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        g_next     = g_reg;
        steps_next = steps_reg;
        conv_next  = conv_reg;
        if (cmd.load) begin
            g_next     = in_zero ? '0 : g_init;
            steps_next = '0;
            conv_next  = in_zero;
        end else if (cmd.step) begin
            steps_next = steps_inc;
            if (g_new == g_reg) begin
                conv_next = 1'b1;
            end else begin
                g_next = g_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            x_reg <= radicand;
        end
        g_reg     <= g_next;
        steps_reg <= steps_next;
        conv_reg  <= conv_next;
        if (cmd.publish) begin
            root_reg      <= root_sat;
            converged_reg <= conv_reg;
            iter_out_reg  <= steps_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_iter_reg  <= MAX_ITER_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_iter_reg <= cfg_wr_data;
            end
            if (cmd.publish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign root            = root_reg;
    assign converged       = converged_reg;
    assign iterations_used = iter_out_reg;

endmodule

`default_nettype wire

[design/nsr_ctrl.sv]
// ----------------------------------------------------------------------------
// nsr_ctrl
// Sequencer for the Newton square root: takes a word, runs division steps (none
// for a zero word) until the guess settles or the limit is reached, then hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_ctrl
    import nsr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire nsr_status_t status,
    output nsr_cmd_t         cmd
);

    nsr_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = status.in_zero ? ST_FINISH : ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done) begin
                    cmd.step = 1'b1;
                    if (status.same || status.limit_hit) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/newton_square_root_core.sv]
// ----------------------------------------------------------------------------
// newton_square_root_core
// A zero radicand goes straight to its result; otherwise the core runs Newton
//   steps until the guess settles or max_iterations (clamped to 1..64) is hit.
// Each step runs the shared restoring divider, one quotient bit a cycle
//   over 32 + FRAC_BITS bits, after a start state, then updates the guess.
// Throughput: one word at a time; the next word is taken once the result
//   enters the output register. Reset clears control and sets max_iterations
//   to 20.
// ----------------------------------------------------------------------------
`default_nettype none

module newton_square_root_core
    import nsr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [ITER_W-1:0]     cfg_wr_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [RADICAND_W-1:0] radicand,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [ROOT_W-1:0]          root,
    output logic                       converged,
    output logic [ITER_W-1:0]          iterations_used
);

    nsr_cmd_t    cmd;
    nsr_status_t status;

    nsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    nsr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .radicand        (radicand),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .root            (root),
        .converged       (converged),
        .iterations_used (iterations_used)
    );

endmodule

`default_nettype wire

[design/nsr_checker.sv]
// ----------------------------------------------------------------------------
// nsr_checker
// Port-level checks for the Newton square root, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_checker
    import nsr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [ROOT_W-1:0]     root,
    input  wire logic                  converged,
    input  wire logic [ITER_W-1:0]     iterations_used
);

    // Once a word is taken, ready is low in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after an accepted word");

    // Only a zero radicand skips the Newton steps, and it gives a root of zero.
    a_zero_steps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (iterations_used == '0) |-> converged && (root == '0))
        else $error("no steps taken but result is not the zero root");

    a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (iterations_used <= MAX_ITER_CAP))
        else $error("more steps reported than the cap allows");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root)
            && $stable(converged) && $stable(iterations_used))
        else $error("result word changed while stalled");

endmodule

bind newton_square_root_core nsr_checker u_nsr_checker (.*);

`default_nettype wire
